// ===== rtl/swr_pkg.sv =====
`default_nettype none
package swr_pkg;
    localparam int KIND_W = 2;
    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;

    localparam logic RES_DELIVER = 1'b0;
    localparam logic RES_ACK     = 1'b1;

    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_ACK_MODE    = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd16;
endpackage
`default_nettype wire

// ===== rtl/swr_in_if.sv =====
`default_nettype none
interface swr_in_if;
    logic                        valid;
    logic                        ready;
    logic [swr_pkg::KIND_W-1:0]  kind;
    logic [swr_pkg::SEQ_W-1:0]   seq_num;
    logic [swr_pkg::LEN_W-1:0]   payload_length;
    logic                        checksum_ok;
    modport source (output valid, kind, seq_num, payload_length, checksum_ok, input ready);
    modport sink   (input valid, kind, seq_num, payload_length, checksum_ok, output ready);
endinterface
`default_nettype wire

// ===== rtl/swr_out_if.sv =====
`default_nettype none
interface swr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [swr_pkg::SEQ_W-1:0]   seq_out;
    logic [swr_pkg::LEN_W-1:0]   length_out;
    logic [swr_pkg::SLOT_W-1:0]  slot;
    logic [swr_pkg::SEQ_W-1:0]   total_bytes;
    logic                        session_end;
    logic                        last;
    modport source (output valid, result_kind, seq_out, length_out, slot, total_bytes,
                    session_end, last, input ready);
    modport sink   (input valid, result_kind, seq_out, length_out, slot, total_bytes,
                    session_end, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sliding_window_receiver.sv =====
`default_nettype none
// Receive side of a selective-repeat window. One packet header is taken per transfer,
// only while the block is idle. An in-window data packet first runs a bit-serial modulo
// of its sequence number by the window size to find its slot, then writes its length
// into the slot memory. If it is the expected packet, each marked slot of the run is
// read from memory and then delivered, and one acknowledgement follows. End packets go
// straight to the acknowledgement; dropped packets give no result. Results leave through
// an output register, so a stalled sink holds the sequencer but not the input side of
// an idle block.
module sliding_window_receiver #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    swr_in_if.sink                          i_pkt,
    swr_out_if.source                       o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [swr_pkg::CFG_W-1:0]  i_cfg_data
);
    import swr_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_WRITE = 6'b000100,
        S_RD    = 6'b001000,
        S_OUT   = 6'b010000,
        S_ACK   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_wsize;
    logic                  r_amode;
    logic [MAX_WINDOW-1:0] r_marks, n_marks;
    logic [SEQ_W-1:0]      r_base, n_base;
    logic [SEQ_W-1:0]      r_total, n_total;
    logic [KIND_W-1:0]     r_kind;
    logic [SEQ_W-1:0]      r_seq;
    logic [LEN_W-1:0]      r_len;
    logic [WW-1:0]         r_rem, n_rem;
    logic [4:0]            r_cnt, n_cnt;
    logic [SW-1:0]         r_s, n_s;
    logic [SEQ_W:0]        r_j, n_j;

    logic [LEN_W-1:0]      r_mem [MAX_WINDOW];
    logic [LEN_W-1:0]      r_rd;
    logic                  mem_we, mem_re;

    logic                  r_ov;
    logic                  r_okind, r_oend, r_olast;
    logic [SEQ_W-1:0]      r_oseq, r_ototal;
    logic [LEN_W-1:0]      r_olen;
    logic [SLOT_W-1:0]     r_oslot;
    logic                  emit, out_free;
    logic                  e_kind, e_end, e_last;
    logic [SEQ_W-1:0]      e_seq, e_total;
    logic [LEN_W-1:0]      e_len;
    logic [SLOT_W-1:0]     e_slot;

    logic [WW-1:0]         w;
    logic [SEQ_W:0]        top;
    logic                  accept;
    logic [WW:0]           trial;
    logic [SEQ_W:0]        sum;

    always_comb begin
        if (r_wsize == '0) begin
            w = WW'(1);
        end else if ({1'b0, r_wsize} > 6'(MAX_WINDOW)) begin
            w = WW'(MAX_WINDOW);
        end else begin
            w = WW'(r_wsize);
        end
    end

    assign top      = {1'b0, r_base} + (SEQ_W + 1)'(w);
    assign accept   = i_pkt.valid && i_pkt.ready;
    assign out_free = !r_ov || o_res.ready;
    assign i_pkt.ready = (r_state == S_IDLE);
    assign trial    = {r_rem, r_seq[~r_cnt]};
    assign sum      = {1'b0, r_total} + (SEQ_W + 1)'(r_rd);

    always_comb begin
        n_state = r_state;
        n_marks = r_marks;
        n_base  = r_base;
        n_total = r_total;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_s     = r_s;
        n_j     = r_j;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        emit    = 1'b0;
        e_kind  = RES_ACK;
        e_seq   = r_seq;
        e_len   = '0;
        e_slot  = '0;
        e_total = r_total;
        e_end   = 1'b0;
        e_last  = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_pkt.kind == KIND_END) begin
                        n_state = S_ACK;
                    end else if (i_pkt.kind == KIND_DATA && i_pkt.checksum_ok
                                 && i_pkt.seq_num >= r_base
                                 && {1'b0, i_pkt.seq_num} < top) begin
                        n_state = S_MOD;
                        n_rem   = '0;
                        n_cnt   = '0;
                    end
                end
            end
            S_MOD: begin
                if (trial >= {1'b0, w}) begin
                    n_rem = WW'(trial - {1'b0, w});
                end else begin
                    n_rem = WW'(trial);
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
                n_marks[SW'(r_rem)] = 1'b1;
                n_s = SW'(r_rem);
                n_j = {1'b0, r_seq};
                n_state = (r_seq == r_base) ? S_RD : S_ACK;
            end
            S_RD: begin
                if (r_j < top && !r_j[SEQ_W] && r_marks[r_s]) begin
                    mem_re  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_base  = r_j[SEQ_W-1:0];
                    n_state = S_ACK;
                end
            end
            S_OUT: begin
                emit    = 1'b1;
                e_kind  = RES_DELIVER;
                e_seq   = r_j[SEQ_W-1:0];
                e_len   = r_rd;
                e_slot  = SLOT_W'(r_s);
                e_total = sum[SEQ_W] ? '1 : sum[SEQ_W-1:0];
                e_last  = 1'b0;
                if (out_free) begin
                    n_total = e_total;
                    n_marks[r_s] = 1'b0;
                    n_j = r_j + 1'b1;
                    n_s = (WW'(r_s) + WW'(1) == w) ? '0 : r_s + SW'(1);
                    n_state = S_RD;
                end
            end
            S_ACK: begin
                emit = 1'b1;
                if (r_kind == KIND_END) begin
                    e_end = 1'b1;
                end else if (!r_amode) begin
                    e_seq = r_base;
                end
                if (out_free) begin
                    if (r_kind == KIND_END) begin
                        n_marks = '0;
                        n_total = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wsize <= WINDOW_SIZE_RESET;
            r_amode <= 1'b0;
            r_marks <= '0;
            r_base  <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_marks <= n_marks;
            r_base  <= n_base;
            r_total <= n_total;
            if (i_cfg_we && i_cfg_idx == CFG_WINDOW_SIZE) begin
                r_wsize <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_ACK_MODE) begin
                r_amode <= i_cfg_data[0];
            end
            if (emit && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_s   <= n_s;
        r_j   <= n_j;
        if (accept) begin
            r_kind <= i_pkt.kind;
            r_seq  <= i_pkt.seq_num;
            r_len  <= i_pkt.payload_length;
        end
        if (emit && out_free) begin
            r_okind  <= e_kind;
            r_oseq   <= e_seq;
            r_olen   <= e_len;
            r_oslot  <= e_slot;
            r_ototal <= e_total;
            r_oend   <= e_end;
            r_olast  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[SW'(r_rem)] <= r_len;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_s];
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.result_kind = r_okind;
    assign o_res.seq_out     = r_oseq;
    assign o_res.length_out  = r_olen;
    assign o_res.slot        = r_oslot;
    assign o_res.total_bytes = r_ototal;
    assign o_res.session_end = r_oend;
    assign o_res.last        = r_olast;
endmodule
`default_nettype wire

// ===== rtl/swr_checker.sv =====
`default_nettype none
module swr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_kind,
    input wire logic [31:0] i_seq,
    input wire logic [10:0] i_len,
    input wire logic [3:0]  i_slot,
    input wire logic        i_end,
    input wire logic        i_last
);
    import swr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_seq) && $stable(i_kind))
        else $error("result changed while stalled");

    a_end_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_end |-> i_kind == RES_ACK && i_last)
        else $error("session end not on a final ack");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == RES_ACK |-> i_len == '0 && i_slot == '0 && i_last)
        else $error("ack carries length or slot");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == RES_DELIVER |-> !i_last && !i_end)
        else $error("delivery marked final");
endmodule

bind sliding_window_receiver swr_checker u_swr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_kind  (o_res.result_kind),
    .i_seq   (o_res.seq_out),
    .i_len   (o_res.length_out),
    .i_slot  (o_res.slot),
    .i_end   (o_res.session_end),
    .i_last  (o_res.last)
);
`default_nettype wire
